### rtl/core/cmpb_pkg.sv
package cmpb_pkg;

  // Defaults for the top-level parameters
  localparam int CELL_COUNT_DEF = 6;
  localparam int ADC_BITS_DEF   = 12;

  // Configuration port
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int MUX_W     = 3;
  localparam int CELL_W    = 16;
  localparam int SCOUNT_W  = 5;
  localparam int THR_W     = 15;
  localparam int LIMIT_W   = 12;
  localparam int COUNTER_W = 4;
  localparam int TAKEN_W   = 5;

  // Samples per tap are clamped to this range
  localparam logic [SCOUNT_W-1:0] SAMPLES_MIN = 5'd1;
  localparam logic [SCOUNT_W-1:0] SAMPLES_MAX = 5'd16;

  // Cell saturation bounds
  localparam int CELL_HI = 32767;
  localparam int CELL_LO = -32768;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERVOLT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BALANCE_TOL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT_ONE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT_TWO = 3'd5;

  // Register reset values
  localparam logic [SCOUNT_W-1:0] RST_SAMPLE_COUNT = 5'd10;
  localparam logic [THR_W-1:0]    RST_UNDERVOLT    = 15'd1862;
  localparam logic [THR_W-1:0]    RST_BALANCE_TOL  = 15'd124;
  localparam logic [LIMIT_W-1:0]  RST_LIMIT        = 12'd4095;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TAP     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CURRENT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_THERM   = 2'd2;

  typedef enum logic [1:0] {
    TRIP_NONE,
    TRIP_UNDERVOLT,
    TRIP_OVERCURRENT,
    TRIP_OVERTEMP
  } trip_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EV_READ,
    ST_EV_CELL,
    ST_EV_CMP,
    ST_EV_TRIP,
    ST_FINISH
  } state_t;

endpackage

### rtl/core/cmpb_ram.sv
module cmpb_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/cmpb_div.sv
module cmpb_div #(
  parameter int DW = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [cmpb_pkg::TAKEN_W-1:0] divisor,
  output logic                       done,
  output logic [DW-1:0]              quotient
);

  localparam int RW = cmpb_pkg::TAKEN_W;
  localparam int CW = $clog2(DW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic [DW-1:0] work;
  logic [RW:0]   shifted;
  logic          ge;
  logic [RW:0]   diff;

  // One restoring step: bring down the next dividend bit
  always_comb begin
    shifted = {rem, work[DW-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  // Control: count one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  // Datapath: remainder and shifting dividend/quotient word
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dvs  <= divisor;
      work <= dividend;
    end else if (busy) begin
      rem  <= ge ? diff[RW-1:0] : shifted[RW-1:0];
      work <= {work[DW-2:0], ge};
    end
  end

  assign quotient = work;

endmodule

### rtl/core/cell_monitor_passive_balancer_unit.sv
// Six-cell stack monitor with passive balancing. Tap samples (cmd 0) arrive in
// round-robin tap order; sample_count of them, clamped to 1..16, are summed per
// tap and the truncated mean is stored. Closing the last tap evaluates every cell
// as tap_i*(i+1) - tap_(i-1)*i, finds the minimum, trips on undervoltage and sets
// a bleed bit for each cell more than balance_tolerance above the minimum.
// Current (cmd 1) and thermistor (cmd 2) samples trip on raw limits; the first
// trip cause latches until reset and forces the balance mask to zero. Each
// item yields one result. One item is worked at a time: a sample that closes a
// tap also runs the bit-serial mean divider, and the sample that closes the last
// tap then makes two passes of the shared cell unit over the tap memory, with
// read, cell and compare steps for each cell in each pass.
module cell_monitor_passive_balancer_unit #(
  parameter int CELL_COUNT = cmpb_pkg::CELL_COUNT_DEF,
  parameter int ADC_BITS   = cmpb_pkg::ADC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cmpb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cmpb_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cmpb_pkg::CMD_W-1:0]        cmd,
  input  logic [ADC_BITS-1:0]               adc_a,
  input  logic [ADC_BITS-1:0]               adc_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [cmpb_pkg::MUX_W-1:0]        mux_channel,
  output logic                              evaluated,
  output logic [CELL_COUNT-1:0]             balance_mask,
  output logic signed [cmpb_pkg::CELL_W-1:0] min_cell,
  output logic [1:0]                        trip_cause
);

  localparam int IW = $clog2(CELL_COUNT);
  localparam int SW = ADC_BITS + 4;
  localparam int LW = (ADC_BITS > cmpb_pkg::LIMIT_W) ? ADC_BITS : cmpb_pkg::LIMIT_W;
  localparam int FW = (ADC_BITS + IW + 3 > 17) ? ADC_BITS + IW + 3 : 17;
  localparam int CW = cmpb_pkg::CELL_W;
  localparam logic [IW-1:0] LAST = IW'(CELL_COUNT - 1);
  localparam logic signed [FW-1:0] SAT_HI = FW'(cmpb_pkg::CELL_HI);
  localparam logic signed [FW-1:0] SAT_LO = FW'(cmpb_pkg::CELL_LO);

  // Configuration registers
  logic [cmpb_pkg::SCOUNT_W-1:0] sample_count;
  logic [cmpb_pkg::THR_W-1:0]    undervolt_threshold;
  logic [cmpb_pkg::THR_W-1:0]    balance_tolerance;
  logic [cmpb_pkg::LIMIT_W-1:0]  current_limit;
  logic [cmpb_pkg::LIMIT_W-1:0]  temp_limit_one;
  logic [cmpb_pkg::LIMIT_W-1:0]  temp_limit_two;

  // Block state
  cmpb_pkg::state_t state, state_next;
  cmpb_pkg::trip_t  trip_latch;
  logic [SW-1:0]                  sample_sum;
  logic [cmpb_pkg::COUNTER_W-1:0] sample_counter;
  logic [IW-1:0]                  channel_index;
  logic [CELL_COUNT-1:0]          mask_reg;
  logic [CELL_COUNT-1:0]          mask_acc;
  logic [CELL_COUNT-1:0]          mask_acc_next;
  logic signed [CW-1:0]           min_reg;
  logic signed [CW-1:0]           cell_reg;
  logic [ADC_BITS-1:0]            prev_tap;
  logic [IW-1:0]                  idx;
  logic                           pass;
  logic                           ev_flag;

  // Handshake and unit controls
  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [SW-1:0]       div_quot;
  logic                ram_we;
  logic [ADC_BITS-1:0] ram_rdata;

  // Intake arithmetic
  logic [SW-1:0]                 sum_next;
  logic [cmpb_pkg::TAKEN_W-1:0]  taken;
  logic [cmpb_pkg::SCOUNT_W-1:0] n_eff;
  logic                          tap_done;
  logic [IW-1:0]                 ch_eff;
  logic [LW-1:0]                 a_ext;
  logic [LW-1:0]                 b_ext;
  logic                          over_current;
  logic                          over_temp;

  // Shared cell unit
  logic signed [ADC_BITS:0] tap_diff;
  logic signed [FW-1:0]     cell_prod;
  logic signed [FW-1:0]     cell_full;
  logic signed [CW-1:0]     cell_sat;
  logic signed [CW:0]       cell_excess;
  logic                     cell_lower;
  logic                     under_volt;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Intake: running sum, sample count clamp and limit compares
  always_comb begin
    sum_next = sample_sum + SW'(adc_a);
    taken    = {1'b0, sample_counter} + cmpb_pkg::TAKEN_W'(1);
    if (sample_count < cmpb_pkg::SAMPLES_MIN) begin
      n_eff = cmpb_pkg::SAMPLES_MIN;
    end else if (sample_count > cmpb_pkg::SAMPLES_MAX) begin
      n_eff = cmpb_pkg::SAMPLES_MAX;
    end else begin
      n_eff = sample_count;
    end
    tap_done     = taken >= n_eff;
    ch_eff       = (channel_index >= LAST) ? LAST : channel_index;
    a_ext        = LW'(adc_a);
    b_ext        = LW'(adc_b);
    over_current = a_ext > LW'(current_limit);
    over_temp    = (a_ext > LW'(temp_limit_one)) || (b_ext > LW'(temp_limit_two));
  end

  // Cell unit: cell = tap_i + (tap_i - tap_(i-1)) * i, saturated
  always_comb begin
    tap_diff  = $signed({1'b0, ram_rdata}) - $signed({1'b0, prev_tap});
    cell_prod = FW'(tap_diff) * FW'($signed({1'b0, idx}));
    cell_full = cell_prod + FW'($signed({1'b0, ram_rdata}));
    if (cell_full > SAT_HI) begin
      cell_sat = CW'(SAT_HI);
    end else if (cell_full < SAT_LO) begin
      cell_sat = CW'(SAT_LO);
    end else begin
      cell_sat = cell_full[CW-1:0];
    end
    cell_excess   = $signed({cell_reg[CW-1], cell_reg}) - $signed({min_reg[CW-1], min_reg});
    cell_lower    = cell_reg < min_reg;
    under_volt    = $signed({min_reg[CW-1], min_reg}) < $signed({2'b00, undervolt_threshold});
    mask_acc_next = mask_acc;
    mask_acc_next[idx] = cell_excess > $signed({2'b00, balance_tolerance});
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cmpb_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = (cmd == cmpb_pkg::CMD_TAP && tap_done) ? cmpb_pkg::ST_DIV
                                                              : cmpb_pkg::ST_FINISH;
        end
      end
      cmpb_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = (ch_eff == LAST) ? cmpb_pkg::ST_EV_READ : cmpb_pkg::ST_FINISH;
        end
      end
      cmpb_pkg::ST_EV_READ: state_next = cmpb_pkg::ST_EV_CELL;
      cmpb_pkg::ST_EV_CELL: state_next = cmpb_pkg::ST_EV_CMP;
      cmpb_pkg::ST_EV_CMP: begin
        if (idx != LAST) begin
          state_next = cmpb_pkg::ST_EV_READ;
        end else begin
          state_next = pass ? cmpb_pkg::ST_FINISH : cmpb_pkg::ST_EV_TRIP;
        end
      end
      cmpb_pkg::ST_EV_TRIP: state_next = cmpb_pkg::ST_EV_READ;
      cmpb_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = cmpb_pkg::ST_IDLE;
        end
      end
      default: state_next = cmpb_pkg::ST_IDLE;
    endcase
  end

  // Controls decoded from state
  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    ram_we    = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      cmpb_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = in_acc && cmd == cmpb_pkg::CMD_TAP && tap_done;
      end
      cmpb_pkg::ST_DIV:    ram_we   = div_done;
      cmpb_pkg::ST_FINISH: out_load = out_free;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmpb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count        <= cmpb_pkg::RST_SAMPLE_COUNT;
      undervolt_threshold <= cmpb_pkg::RST_UNDERVOLT;
      balance_tolerance   <= cmpb_pkg::RST_BALANCE_TOL;
      current_limit       <= cmpb_pkg::RST_LIMIT;
      temp_limit_one      <= cmpb_pkg::RST_LIMIT;
      temp_limit_two      <= cmpb_pkg::RST_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cmpb_pkg::REG_SAMPLE_COUNT:   sample_count <= cfg_data[cmpb_pkg::SCOUNT_W-1:0];
        cmpb_pkg::REG_UNDERVOLT:      undervolt_threshold <= cfg_data;
        cmpb_pkg::REG_BALANCE_TOL:    balance_tolerance <= cfg_data;
        cmpb_pkg::REG_CURRENT_LIMIT:  current_limit <= cfg_data[cmpb_pkg::LIMIT_W-1:0];
        cmpb_pkg::REG_TEMP_LIMIT_ONE: temp_limit_one <= cfg_data[cmpb_pkg::LIMIT_W-1:0];
        cmpb_pkg::REG_TEMP_LIMIT_TWO: temp_limit_two <= cfg_data[cmpb_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state: sums, channel walk, trips, mask and minimum
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum     <= '0;
      sample_counter <= '0;
      channel_index  <= '0;
      mask_reg       <= '0;
      min_reg        <= '0;
      trip_latch     <= cmpb_pkg::TRIP_NONE;
      idx            <= '0;
      pass           <= 1'b0;
      ev_flag        <= 1'b0;
    end else begin
      unique case (state)
        cmpb_pkg::ST_IDLE: begin
          if (in_acc) begin
            ev_flag <= 1'b0;
            unique case (cmd)
              cmpb_pkg::CMD_TAP: begin
                // Divider latches the sum at start, so clear right away
                if (tap_done) begin
                  sample_sum     <= '0;
                  sample_counter <= '0;
                end else begin
                  sample_sum     <= sum_next;
                  sample_counter <= taken[cmpb_pkg::COUNTER_W-1:0];
                end
              end
              cmpb_pkg::CMD_CURRENT: begin
                if (over_current && trip_latch == cmpb_pkg::TRIP_NONE) begin
                  trip_latch <= cmpb_pkg::TRIP_OVERCURRENT;
                  mask_reg   <= '0;
                end
              end
              cmpb_pkg::CMD_THERM: begin
                if (over_temp && trip_latch == cmpb_pkg::TRIP_NONE) begin
                  trip_latch <= cmpb_pkg::TRIP_OVERTEMP;
                  mask_reg   <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        cmpb_pkg::ST_DIV: begin
          // Advance to the next tap, or start the round on the last one
          if (div_done) begin
            if (ch_eff == LAST) begin
              channel_index <= '0;
              idx           <= '0;
              pass          <= 1'b0;
            end else begin
              channel_index <= ch_eff + IW'(1);
            end
          end
        end
        cmpb_pkg::ST_EV_CMP: begin
          if (!pass) begin
            if (idx == '0 || cell_lower) begin
              min_reg <= cell_reg;
            end
          end else if (idx == LAST) begin
            mask_reg <= (trip_latch != cmpb_pkg::TRIP_NONE) ? '0 : mask_acc_next;
            ev_flag  <= 1'b1;
          end
          idx <= (idx == LAST) ? '0 : idx + IW'(1);
        end
        cmpb_pkg::ST_EV_TRIP: begin
          if (under_volt && trip_latch == cmpb_pkg::TRIP_NONE) begin
            trip_latch <= cmpb_pkg::TRIP_UNDERVOLT;
            mask_reg   <= '0;
          end
          pass <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Cell unit registers
  always_ff @(posedge clk) begin
    if (state == cmpb_pkg::ST_EV_CELL) begin
      cell_reg <= cell_sat;
      prev_tap <= ram_rdata;
    end
    if (state == cmpb_pkg::ST_EV_CMP && pass) begin
      mask_acc <= mask_acc_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mux_channel  <= cmpb_pkg::MUX_W'(channel_index);
      evaluated    <= ev_flag;
      balance_mask <= mask_reg;
      min_cell     <= min_reg;
      trip_cause   <= trip_latch;
    end
  end

  // Tap averages
  cmpb_ram #(
    .WIDTH(ADC_BITS),
    .DEPTH(CELL_COUNT)
  ) u_tap_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ch_eff),
    .wdata(div_quot[ADC_BITS-1:0]),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  // Mean divider
  cmpb_div #(
    .DW(SW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_next),
    .divisor (taken),
    .done    (div_done),
    .quotient(div_quot)
  );

  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    trip_latch != cmpb_pkg::TRIP_NONE |=> trip_latch == $past(trip_latch))
    else $error("latched trip cause changed");

  a_mask_clear_on_trip: assert property (@(posedge clk) disable iff (rst)
    trip_latch != cmpb_pkg::TRIP_NONE |-> mask_reg == '0)
    else $error("balance mask set while tripped");

  a_round_wraps: assert property (@(posedge clk) disable iff (rst)
    out_valid && evaluated |-> mux_channel == '0)
    else $error("evaluated round did not wrap the tap channel");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == cmpb_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

endmodule

### bench/cell_monitor_passive_balancer_unit_tb.sv
module cell_monitor_passive_balancer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCELL = cmpb_pkg::CELL_COUNT_DEF;
  localparam int ADC_W = cmpb_pkg::ADC_BITS_DEF;
  localparam int ADC_MAX = (1 << ADC_W) - 1;
  localparam int LIMIT_MAX = (1 << cmpb_pkg::LIMIT_W) - 1;
  localparam int THR_MAX = 24570;
  localparam int FLAT_TAP = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [cmpb_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [cmpb_pkg::CFG_IDX_W-1:0] REG_ORDER [6] = '{
    cmpb_pkg::REG_SAMPLE_COUNT, cmpb_pkg::REG_UNDERVOLT, cmpb_pkg::REG_BALANCE_TOL,
    cmpb_pkg::REG_CURRENT_LIMIT, cmpb_pkg::REG_TEMP_LIMIT_ONE, cmpb_pkg::REG_TEMP_LIMIT_TWO};

  typedef struct {
    int mux;
    int evaluated;
    int mask;
    int min_cell;
    int trip;
  } report_t;

  // Tracks the stack state and predicts one report per accepted item
  class balancer_checker;
    logic [cmpb_pkg::SCOUNT_W-1:0] samples_cfg;
    logic [cmpb_pkg::THR_W-1:0] undervolt;
    logic [cmpb_pkg::THR_W-1:0] tolerance;
    logic [cmpb_pkg::LIMIT_W-1:0] current_lim;
    logic [cmpb_pkg::LIMIT_W-1:0] temp_lim_one;
    logic [cmpb_pkg::LIMIT_W-1:0] temp_lim_two;
    int unsigned tap_mean [NCELL];
    int unsigned acc_sum;
    int unsigned acc_count;
    int unsigned channel;
    logic [NCELL-1:0] bleed;
    int lowest;
    cmpb_pkg::trip_t latched;
    bit round_closed;
    report_t pending[$];
    int errors;

    function new();
      samples_cfg = cmpb_pkg::RST_SAMPLE_COUNT;
      undervolt = cmpb_pkg::RST_UNDERVOLT;
      tolerance = cmpb_pkg::RST_BALANCE_TOL;
      current_lim = cmpb_pkg::RST_LIMIT;
      temp_lim_one = cmpb_pkg::RST_LIMIT;
      temp_lim_two = cmpb_pkg::RST_LIMIT;
      foreach (tap_mean[i]) tap_mean[i] = 0;
      acc_sum = 0;
      acc_count = 0;
      channel = 0;
      bleed = '0;
      lowest = 0;
      latched = cmpb_pkg::TRIP_NONE;
      round_closed = 1'b0;
      errors = 0;
    endfunction

    function void write_reg(logic [cmpb_pkg::CFG_IDX_W-1:0] idx,
                            logic [cmpb_pkg::CFG_W-1:0] data);
      case (idx)
        cmpb_pkg::REG_SAMPLE_COUNT:   samples_cfg = data[cmpb_pkg::SCOUNT_W-1:0];
        cmpb_pkg::REG_UNDERVOLT:      undervolt = data[cmpb_pkg::THR_W-1:0];
        cmpb_pkg::REG_BALANCE_TOL:    tolerance = data[cmpb_pkg::THR_W-1:0];
        cmpb_pkg::REG_CURRENT_LIMIT:  current_lim = data[cmpb_pkg::LIMIT_W-1:0];
        cmpb_pkg::REG_TEMP_LIMIT_ONE: temp_lim_one = data[cmpb_pkg::LIMIT_W-1:0];
        cmpb_pkg::REG_TEMP_LIMIT_TWO: temp_lim_two = data[cmpb_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Clamp the configured count into the supported range
    function int samples_per_tap();
      int n;
      n = int'(samples_cfg);
      if (n < int'(cmpb_pkg::SAMPLES_MIN)) n = int'(cmpb_pkg::SAMPLES_MIN);
      if (n > int'(cmpb_pkg::SAMPLES_MAX)) n = int'(cmpb_pkg::SAMPLES_MAX);
      return n;
    endfunction

    // Keep the first cause only; a trip clears the bleed mask
    function void latch_trip(cmpb_pkg::trip_t cause);
      if (latched == cmpb_pkg::TRIP_NONE) begin
        latched = cause;
        bleed = '0;
      end
    endfunction

    // Derive cells from tap means, find the minimum, trip or set bleed bits
    function void evaluate_stack();
      int cells [NCELL];
      int mn;
      logic [NCELL-1:0] m;
      mn = 0;
      m = '0;
      for (int i = 0; i < NCELL; i++) begin
        cells[i] = int'(tap_mean[i]) * (i + 1);
        if (i > 0) cells[i] -= int'(tap_mean[i-1]) * i;
        if (cells[i] > cmpb_pkg::CELL_HI) cells[i] = cmpb_pkg::CELL_HI;
        if (cells[i] < cmpb_pkg::CELL_LO) cells[i] = cmpb_pkg::CELL_LO;
        if (i == 0 || cells[i] < mn) mn = cells[i];
      end
      lowest = mn;
      if (mn < int'(undervolt)) latch_trip(cmpb_pkg::TRIP_UNDERVOLT);
      for (int i = 0; i < NCELL; i++) begin
        if (cells[i] - mn > int'(tolerance)) m[i] = 1'b1;
      end
      bleed = (latched != cmpb_pkg::TRIP_NONE) ? '0 : m;
    endfunction

    function void note_sample(logic [cmpb_pkg::CMD_W-1:0] c, logic [ADC_W-1:0] a,
                              logic [ADC_W-1:0] b);
      report_t r;
      int n;
      int unsigned taken;
      int unsigned ch;
      round_closed = 1'b0;
      case (c)
        cmpb_pkg::CMD_TAP: begin
          n = samples_per_tap();
          acc_sum += a;
          taken = acc_count + 1;
          if (taken >= n) begin
            ch = (channel >= NCELL) ? NCELL - 1 : channel;
            tap_mean[ch] = (acc_sum / taken) & ADC_MAX;
            acc_sum = 0;
            acc_count = 0;
            if (ch >= NCELL - 1) begin
              channel = 0;
              evaluate_stack();
              round_closed = 1'b1;
            end else begin
              channel = ch + 1;
            end
          end else begin
            acc_count = taken;
          end
        end
        cmpb_pkg::CMD_CURRENT:
          if (a > current_lim) latch_trip(cmpb_pkg::TRIP_OVERCURRENT);
        cmpb_pkg::CMD_THERM:
          if (a > temp_lim_one || b > temp_lim_two) latch_trip(cmpb_pkg::TRIP_OVERTEMP);
        default: ;
      endcase
      r.mux = channel;
      r.evaluated = int'(round_closed);
      r.mask = int'(bleed);
      r.min_cell = lowest;
      r.trip = int'(latched);
      pending.push_back(r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(int mux, int ev, int mask, int mn, int trip);
      report_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: report with no item outstanding, expected none actual mux %0d ev %0d",
                 $time, mux, ev);
        return;
      end
      want = pending.pop_front();
      compare_field("mux_channel", want.mux, mux);
      compare_field("evaluated", want.evaluated, ev);
      compare_field("balance_mask", want.mask, mask);
      compare_field("min_cell", want.min_cell, mn);
      compare_field("trip_cause", want.trip, trip);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [cmpb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cmpb_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [cmpb_pkg::CMD_W-1:0] cmd;
  logic [ADC_W-1:0] adc_a;
  logic [ADC_W-1:0] adc_b;
  logic out_valid;
  logic out_stall;
  logic [cmpb_pkg::MUX_W-1:0] mux_channel;
  logic evaluated;
  logic [NCELL-1:0] balance_mask;
  logic signed [cmpb_pkg::CELL_W-1:0] min_cell;
  logic [1:0] trip_cause;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_request;
  int cycles;

  balancer_checker chk = new();

  cell_monitor_passive_balancer_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .adc_a(adc_a),
    .adc_b(adc_b),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .mux_channel(mux_channel),
    .evaluated(evaluated),
    .balance_mask(balance_mask),
    .min_cell(min_cell),
    .trip_cause(trip_cause)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Offer one item, hold it until accepted, then return at the next falling edge
  task automatic send_item(logic [cmpb_pkg::CMD_W-1:0] c, int a, int b);
    if (tx_idle_on && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    cmd <= c;
    adc_a <= a[ADC_W-1:0];
    adc_b <= b[ADC_W-1:0];
    do @(posedge clk); while (in_stall);
    chk.note_sample(c, a[ADC_W-1:0], b[ADC_W-1:0]);
    @(negedge clk);
  endtask

  // Stop offering and wait for every outstanding report
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (chk.pending.size() != 0) @(negedge clk);
  endtask

  // Write every register with the block idle
  task automatic apply_settings(int sc, int uv, int tol, int cl, int t1, int t2);
    int vals [6];
    drain();
    vals = '{sc, uv, tol, cl, t1, t2};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data <= vals[i][cmpb_pkg::CFG_W-1:0];
      @(posedge clk);
      chk.write_reg(REG_ORDER[i], vals[i][cmpb_pkg::CFG_W-1:0]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Current, thermistor or unused item that stays within the limits
  task automatic send_noise();
    case ($urandom_range(2))
      0: send_item(cmpb_pkg::CMD_CURRENT,
                   ($urandom_range(3) == 0) ? int'(chk.current_lim)
                                            : int'($urandom_range(chk.current_lim)),
                   int'($urandom_range(ADC_MAX)));
      1: send_item(cmpb_pkg::CMD_THERM,
                   ($urandom_range(3) == 0) ? int'(chk.temp_lim_one)
                                            : int'($urandom_range(chk.temp_lim_one)),
                   ($urandom_range(3) == 0) ? int'(chk.temp_lim_two)
                                            : int'($urandom_range(chk.temp_lim_two)));
      default: send_item(CMD_UNUSED, int'($urandom_range(ADC_MAX)),
                         int'($urandom_range(ADC_MAX)));
    endcase
  endtask

  // One full set of taps: every tap but the last flat, the last one given
  task automatic send_flat_round(int last_tap);
    for (int i = 0; i < NCELL; i++)
      send_item(cmpb_pkg::CMD_TAP, (i == NCELL - 1) ? last_tap : FLAT_TAP,
                int'($urandom_range(ADC_MAX)));
  endtask

  // Random healthy stack: cells at or above base, samples jittered around the tap means
  task automatic random_round(int base, int jitter, int noise_pct);
    int cells [NCELL];
    int target [NCELL];
    int run;
    int spread;
    int v;
    run = 0;
    spread = $urandom_range(600);
    for (int i = 0; i < NCELL; i++) begin
      cells[i] = base + int'($urandom_range(spread));
      run += cells[i];
      target[i] = run / (i + 1);
    end
    do begin
      if ($urandom_range(99) < noise_pct) send_noise();
      v = target[chk.channel] + int'($urandom_range(2 * jitter)) - jitter;
      if (v < 0) v = 0;
      if (v > ADC_MAX) v = ADC_MAX;
      send_item(cmpb_pkg::CMD_TAP, v, int'($urandom_range(ADC_MAX)));
    end while (!chk.round_closed);
  endtask

  // Results side: random stall, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= rx_idle_on && ($urandom_range(99) < 16);
    end
  end

  // Compare each accepted report
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      chk.check_report(int'(mux_channel), int'(evaluated), int'(balance_mask),
                       int'(min_cell), int'(trip_cause));
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cmpb_pkg::trip_t first_trip;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = cmpb_pkg::REG_SAMPLE_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = cmpb_pkg::CMD_TAP;
    adc_a = '0;
    adc_b = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_request = 1'b0;
    cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset limits sit at full scale, so full-scale readings must not trip
    send_item(CMD_UNUSED, ADC_MAX, ADC_MAX);
    send_item(cmpb_pkg::CMD_CURRENT, ADC_MAX, 0);
    send_item(cmpb_pkg::CMD_THERM, ADC_MAX, ADC_MAX);
    send_item(cmpb_pkg::CMD_CURRENT, 0, ADC_MAX);
    send_item(cmpb_pkg::CMD_THERM, 0, 0);

    // Minimum equal to threshold, and a cell exactly at then just over tolerance
    apply_settings(1, FLAT_TAP, 6, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    send_flat_round(FLAT_TAP);
    send_flat_round(FLAT_TAP + 1);
    apply_settings(1, FLAT_TAP, 5, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    send_flat_round(FLAT_TAP + 1);

    // Single samples per tap, with one long hold-off on the results side
    apply_settings(1, int'(cmpb_pkg::RST_UNDERVOLT), int'(cmpb_pkg::RST_BALANCE_TOL),
                   2000, 3000, 1000);
    for (int r = 0; r < 40; r++) begin
      if (r == 12) hold_request = 1'b1;
      random_round(int'(chk.undervolt) + 100, 3, 20);
    end

    // Count of zero, zero tolerance and threshold, no idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    apply_settings(0, 0, 0, LIMIT_MAX, LIMIT_MAX, LIMIT_MAX);
    repeat (25) random_round(100, 2, 15);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Count above the clamp, widest tolerance
    apply_settings(31, 1000, THR_MAX, 3500, 2500, LIMIT_MAX);
    repeat (3) random_round(1100, 6, 10);

    // Leave a tap part way, then shrink the count so the next sample closes it
    repeat (7) send_item(cmpb_pkg::CMD_TAP, 1500, int'($urandom_range(ADC_MAX)));
    apply_settings(4, 0, 300, 3500, 2500, LIMIT_MAX);
    random_round(1400, 4, 10);

    // Small random counts and random settings
    repeat (3) begin
      apply_settings($urandom_range(2, 6), $urandom_range(1500, 2200), $urandom_range(400),
                     $urandom_range(1000, LIMIT_MAX), $urandom_range(1000, LIMIT_MAX),
                     $urandom_range(1000, LIMIT_MAX));
      repeat (4) random_round(int'(chk.undervolt) + 100, 3, 20);
    end

    // Latch one cause first, picked at random
    first_trip = cmpb_pkg::trip_t'($urandom_range(int'(cmpb_pkg::TRIP_UNDERVOLT),
                                                  int'(cmpb_pkg::TRIP_OVERTEMP)));
    case (first_trip)
      cmpb_pkg::TRIP_UNDERVOLT: begin
        apply_settings(1, THR_MAX, int'(cmpb_pkg::RST_BALANCE_TOL), LIMIT_MAX, LIMIT_MAX,
                       LIMIT_MAX);
        random_round(1800, 3, 10);
      end
      cmpb_pkg::TRIP_OVERCURRENT: begin
        apply_settings(1, 0, int'(cmpb_pkg::RST_BALANCE_TOL), 0, LIMIT_MAX, LIMIT_MAX);
        send_item(cmpb_pkg::CMD_CURRENT, int'($urandom_range(1, ADC_MAX)),
                  int'($urandom_range(ADC_MAX)));
      end
      default: begin
        apply_settings(1, 0, int'(cmpb_pkg::RST_BALANCE_TOL), LIMIT_MAX, 0, 0);
        send_item(cmpb_pkg::CMD_THERM, int'($urandom_range(1, ADC_MAX)),
                  int'($urandom_range(ADC_MAX)));
      end
    endcase
    random_round(1800, 3, 20);

    // Later causes must not replace the latched one
    apply_settings(3, THR_MAX, 0, 0, 0, 0);
    send_item(cmpb_pkg::CMD_CURRENT, ADC_MAX, 0);
    send_item(cmpb_pkg::CMD_THERM, 0, ADC_MAX);
    send_item(cmpb_pkg::CMD_THERM, ADC_MAX, 0);
    repeat (2) random_round(1800, 3, 30);

    // Broken stacks and raw noise: negative cells, random commands and values
    repeat (4) begin
      do send_item(cmpb_pkg::CMD_TAP, int'($urandom_range(ADC_MAX)),
                   int'($urandom_range(ADC_MAX)));
      while (!chk.round_closed);
    end
    repeat (60) send_item(cmpb_pkg::CMD_W'($urandom_range(3)), int'($urandom_range(ADC_MAX)),
                          int'($urandom_range(ADC_MAX)));

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (chk.errors == 0 && chk.pending.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

### filelist.f
rtl/core/cmpb_pkg.sv
rtl/core/cmpb_ram.sv
rtl/core/cmpb_div.sv
rtl/core/cell_monitor_passive_balancer_unit.sv
bench/cell_monitor_passive_balancer_unit_tb.sv
